[rtl/core/lpg_pkg.sv]
// lpg_pkg: shared types, constants and helpers of the line pixel generator
// no dependencies; imported by every module of the block
package lpg_pkg;

  // coordinate and decision widths
  localparam int COORD_BITS = 10;
  localparam int DEC_BITS   = COORD_BITS + 3;
  localparam int COLOR_BITS = 24;

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic signed [DEC_BITS-1:0] dec_t;
  typedef logic [COLOR_BITS-1:0]      color_t;
  typedef logic [1:0]                 oct_t;

  // command codes
  localparam logic CMD_BEGIN = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // octant cases
  localparam oct_t OCT_SHALLOW_UP   = 2'd0;
  localparam oct_t OCT_STEEP_UP     = 2'd1;
  localparam oct_t OCT_STEEP_DOWN   = 2'd2;
  localparam oct_t OCT_SHALLOW_DOWN = 2'd3;

  // walker state of one line
  typedef struct packed {
    coord_t cur_x;
    coord_t cur_y;
    coord_t stop_x;
    coord_t stop_y;
    coord_t delta_x;
    coord_t delta_y;
    dec_t   decision;
    oct_t   octant;
  } line_state_t;

  // zero-extend a coordinate into the signed decision width
  function automatic dec_t widen(coord_t v);
    return dec_t'({{(DEC_BITS-COORD_BITS){1'b0}}, v});
  endfunction

endpackage

[rtl/core/lpg_setup.sv]
// lpg_setup: endpoint ordering, extents, octant choice and starting decision
// depends on lpg_pkg
module lpg_setup (
  input  lpg_pkg::coord_t      x_start,
  input  lpg_pkg::coord_t      y_start,
  input  lpg_pkg::coord_t      x_end,
  input  lpg_pkg::coord_t      y_end,
  output lpg_pkg::line_state_t line_init
);
  import lpg_pkg::*;

  logic   swap;
  coord_t x0, y0, x1, y1;
  coord_t dx, ady;
  logic   dy_neg;
  oct_t   oct;
  dec_t   dec_shallow, dec_steep;

  // order endpoints so that x never falls
  assign swap = x_start > x_end;
  assign x0   = swap ? x_end   : x_start;
  assign y0   = swap ? y_end   : y_start;
  assign x1   = swap ? x_start : x_end;
  assign y1   = swap ? y_start : y_end;

  // extents of the line
  assign dx     = x1 - x0;
  assign dy_neg = y1 < y0;
  assign ady    = dy_neg ? (y0 - y1) : (y1 - y0);

  // octant choice
  always_comb begin
    if (!dy_neg && ady <= dx) begin
      oct = OCT_SHALLOW_UP;
    end else if (!dy_neg) begin
      oct = OCT_STEEP_UP;
    end else if (ady >= dx) begin
      oct = OCT_STEEP_DOWN;
    end else begin
      oct = OCT_SHALLOW_DOWN;
    end
  end

  // midpoint starting values
  assign dec_shallow = (widen(ady) <<< 1) - widen(dx);
  assign dec_steep   = widen(ady) - (widen(dx) <<< 1);

  always_comb begin
    line_init.cur_x   = x0;
    line_init.cur_y   = y0;
    line_init.stop_x  = x1;
    line_init.stop_y  = y1;
    line_init.delta_x = dx;
    line_init.delta_y = ady;
    line_init.octant  = oct;
    case (oct)
      OCT_SHALLOW_UP, OCT_SHALLOW_DOWN: line_init.decision = dec_shallow;
      default:                          line_init.decision = dec_steep;
    endcase
  end

endmodule

[rtl/core/lpg_step.sv]
// lpg_step: end-of-line test and one error-term step of the walker
// depends on lpg_pkg
module lpg_step (
  input  lpg_pkg::line_state_t cur,
  output logic                 last,
  output lpg_pkg::line_state_t nxt
);
  import lpg_pkg::*;

  dec_t twice_dx, twice_dy;

  assign twice_dx = widen(cur.delta_x) <<< 1;
  assign twice_dy = widen(cur.delta_y) <<< 1;

  // the major axis decides when the end point is reached
  always_comb begin
    if (cur.octant inside {OCT_SHALLOW_UP, OCT_SHALLOW_DOWN}) begin
      last = cur.cur_x == cur.stop_x;
    end else begin
      last = cur.cur_y == cur.stop_y;
    end
  end

  // one step along the major axis, minor axis by the error term
  always_comb begin
    nxt = cur;
    case (cur.octant)
      OCT_SHALLOW_UP: begin
        if (cur.decision > 0) begin
          nxt.cur_y    = cur.cur_y + coord_t'(1);
          nxt.decision = cur.decision - twice_dx + twice_dy;
        end else begin
          nxt.decision = cur.decision + twice_dy;
        end
        nxt.cur_x = cur.cur_x + coord_t'(1);
      end
      OCT_STEEP_UP: begin
        if (cur.decision < 0) begin
          nxt.cur_x    = cur.cur_x + coord_t'(1);
          nxt.decision = cur.decision + twice_dy - twice_dx;
        end else begin
          nxt.decision = cur.decision - twice_dx;
        end
        nxt.cur_y = cur.cur_y + coord_t'(1);
      end
      OCT_STEEP_DOWN: begin
        if (cur.decision < 0) begin
          nxt.cur_x    = cur.cur_x + coord_t'(1);
          nxt.decision = cur.decision + twice_dy - twice_dx;
        end else begin
          nxt.decision = cur.decision - twice_dx;
        end
        nxt.cur_y = cur.cur_y - coord_t'(1);
      end
      default: begin
        if (cur.decision > 0) begin
          nxt.cur_y    = cur.cur_y - coord_t'(1);
          nxt.decision = cur.decision - twice_dx + twice_dy;
        end else begin
          nxt.decision = cur.decision + twice_dy;
        end
        nxt.cur_x = cur.cur_x + coord_t'(1);
      end
    endcase
  end

endmodule

[rtl/core/line_pixel_generator_top.sv]
// Line pixel generator: a begin word loads two endpoints and a pen colour and
// emits the first pixel of the line at once; each step word emits the next
// pixel, the final one flagged by last_pixel. A step word while no line is
// active is consumed and gives no pixel. One word is taken every clock and a
// pixel leaves every clock when the output is not stalled: a word is captured
// in the input register, the setup and step logic run in a single pass, and
// the pixel is then registered in the result register once that is free.
// Both channels use valid/ready; while a finished pixel waits, the input
// register still takes one word, and any word (a step with no line included)
// leaves it only once the result register is free.
// depends on lpg_pkg, lpg_setup, lpg_step
module line_pixel_generator_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  logic                command,
  input  lpg_pkg::coord_t     x_start,
  input  lpg_pkg::coord_t     y_start,
  input  lpg_pkg::coord_t     x_end,
  input  lpg_pkg::coord_t     y_end,
  input  lpg_pkg::color_t     pen_color,
  output logic                pixel_valid,
  input  logic                pixel_ready,
  output lpg_pkg::coord_t     pixel_x,
  output lpg_pkg::coord_t     pixel_y,
  output lpg_pkg::color_t     pixel_color,
  output logic                last_pixel
);
  import lpg_pkg::*;

  // input register
  logic   hold_full;
  logic   hold_command;
  coord_t hold_x_start, hold_y_start, hold_x_end, hold_y_end;
  color_t hold_color;

  // line state
  line_state_t st;
  logic        line_active;
  color_t      held_color;

  line_state_t setup_state, base, stepped;
  logic        is_begin, emits, at_last, fire;
  color_t      color_sel;

  assign fire      = hold_full && (!pixel_valid || pixel_ready);
  assign cmd_ready = !hold_full || fire;

  // capture the incoming word
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_full <= 1'b0;
    end else if (cmd_ready) begin
      hold_full <= cmd_valid;
    end
    if (cmd_valid && cmd_ready) begin
      hold_command <= command;
      hold_x_start <= x_start;
      hold_y_start <= y_start;
      hold_x_end   <= x_end;
      hold_y_end   <= y_end;
      hold_color   <= pen_color;
    end
  end

  lpg_setup u_setup (
    .x_start   (hold_x_start),
    .y_start   (hold_y_start),
    .x_end     (hold_x_end),
    .y_end     (hold_y_end),
    .line_init (setup_state)
  );

  // a begin word starts from fresh state, a step word from the walker
  assign is_begin  = hold_command == CMD_BEGIN;
  assign base      = is_begin ? setup_state : st;
  assign color_sel = is_begin ? hold_color : held_color;
  assign emits     = is_begin || line_active;

  lpg_step u_step (
    .cur  (base),
    .last (at_last),
    .nxt  (stepped)
  );

  // walker state update
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (fire && emits) begin
      line_active <= !at_last;
    end
    if (fire && emits) begin
      st         <= at_last ? base : stepped;
      held_color <= color_sel;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (fire && emits) begin
      pixel_valid <= 1'b1;
    end else if (pixel_ready) begin
      pixel_valid <= 1'b0;
    end
    if (fire && emits) begin
      pixel_x     <= base.cur_x;
      pixel_y     <= base.cur_y;
      pixel_color <= color_sel;
      last_pixel  <= at_last;
    end
  end

endmodule

[rtl/core/lpg_checker.sv]
// lpg_checker: port-level checks of the line pixel generator
// depends on lpg_pkg; bound to line_pixel_generator_top
module lpg_checker (
  input logic            clk,
  input logic            rst,
  input logic            cmd_valid,
  input logic            cmd_ready,
  input logic            command,
  input lpg_pkg::coord_t x_start,
  input lpg_pkg::coord_t y_start,
  input lpg_pkg::coord_t x_end,
  input lpg_pkg::coord_t y_end,
  input lpg_pkg::color_t pen_color,
  input logic            pixel_valid,
  input logic            pixel_ready,
  input lpg_pkg::coord_t pixel_x,
  input lpg_pkg::coord_t pixel_y,
  input lpg_pkg::color_t pixel_color,
  input logic            last_pixel
);
  import lpg_pkg::*;

  // a waiting command word holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_ready |=> cmd_valid && $stable(command) && $stable(x_start)
      && $stable(y_start) && $stable(x_end) && $stable(y_end) && $stable(pen_color))
    else $error("waiting command word changed");

  // a stalled pixel word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_ready |=> pixel_valid && $stable(pixel_x) && $stable(pixel_y)
      && $stable(pixel_color) && $stable(last_pixel))
    else $error("stalled pixel word changed");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !pixel_valid)
    else $error("pixel word present after reset");

  // input never blocks while the output side can drain
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    (!pixel_valid || pixel_ready) |-> cmd_ready)
    else $error("input stalled with free output");

endmodule

bind line_pixel_generator_top lpg_checker u_lpg_checker (.*);
